// File: sv/nearest_palette_color_top_defines.svh
// Assertion helpers for the top-level RTL file.
`ifndef NEAREST_PALETTE_COLOR_TOP_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define NPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define NPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/npc_pkg.sv
`default_nettype none

package npc_pkg;

  // Default palette depth
  localparam int PALETTE_ENTRIES = 256;

  // Field widths
  localparam int ChanW  = 8;
  localparam int IdxW   = 8;
  localparam int DistW  = 18;  // 3 * 255^2 fits in 18 bits
  localparam int BoundW = DistW + 1;  // bound is twice the query magnitude

  // Operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // One RGB color
  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_BOUND = 3'b010,
    ST_WALK  = 3'b100
  } npc_state_e;

endpackage

`default_nettype wire

// File: sv/npc_ram.sv
`default_nettype none

module npc_ram #(
  parameter int Width = 24,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: sv/npc_dist.sv
`default_nettype none

module npc_dist (
  input  wire logic                       clk_i,
  input  wire npc_pkg::rgb_t              color_a_i,
  input  wire npc_pkg::rgb_t              color_b_i,
  output logic      [npc_pkg::DistW-1:0]  dist_o
);
  import npc_pkg::*;

  logic [ChanW-1:0]   diff_r, diff_g, diff_b;
  logic [2*ChanW-1:0] sq_r, sq_g, sq_b;

  // Absolute channel differences
  assign diff_r = (color_a_i.red >= color_b_i.red) ? color_a_i.red - color_b_i.red
                                                   : color_b_i.red - color_a_i.red;
  assign diff_g = (color_a_i.green >= color_b_i.green)
                ? color_a_i.green - color_b_i.green : color_b_i.green - color_a_i.green;
  assign diff_b = (color_a_i.blue >= color_b_i.blue)
                ? color_a_i.blue - color_b_i.blue : color_b_i.blue - color_a_i.blue;

  // 8x8 squares
  assign sq_r = diff_r * diff_r;
  assign sq_g = diff_g * diff_g;
  assign sq_b = diff_b * diff_b;

  // Registered squared distance
  always_ff @(posedge clk_i) begin
    dist_o <= DistW'(sq_r) + DistW'(sq_g) + DistW'(sq_b);
  end

endmodule

`default_nettype wire

// File: sv/nearest_palette_color_top.sv
// Nearest palette color search. A load word (operation 0) writes one palette entry in the
// cycle it is accepted and gives no result; busy stays low. A query word (operation 1)
// walks the inclusive index range through one shared squared-distance unit, one palette
// read and one distance per cycle: busy stays high for the walk, and the result strobe
// done_o follows in the next cycle. A zero distance below the bound ends the walk early
// (a black query has a zero bound, so it never does); an empty range answers in the cycle
// after acceptance with no busy time. done_o is high for exactly one cycle and cannot be
// held off, so the receiver must take best_index_o and exact_match_o in that cycle.
`default_nettype none

module nearest_palette_color_top #(
  parameter int PalEntries = npc_pkg::PALETTE_ENTRIES
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       operation_i,
  input  wire logic [npc_pkg::IdxW-1:0]   entry_index_i,
  input  wire logic [npc_pkg::ChanW-1:0]  red_i,
  input  wire logic [npc_pkg::ChanW-1:0]  green_i,
  input  wire logic [npc_pkg::ChanW-1:0]  blue_i,
  input  wire logic [npc_pkg::IdxW-1:0]   range_first_i,
  input  wire logic [npc_pkg::IdxW-1:0]   range_last_i,
  output logic                            done_o,
  output logic      [npc_pkg::IdxW-1:0]   best_index_o,
  output logic                            exact_match_o
);
  import npc_pkg::*;

  `include "nearest_palette_color_top_defines.svh"

  localparam int AddrW   = $clog2(PalEntries);
  localparam int LastMax = (PalEntries > (1 << IdxW)) ? (1 << IdxW) - 1 : PalEntries - 1;

  npc_state_e         state_q, state_d;
  rgb_t               color_q, color_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [IdxW-1:0]    last_q, last_d;
  logic               issue_done_q, issue_done_d;
  logic               rd_vld_q, rd_vld_d;
  logic [IdxW-1:0]    rd_idx_q, rd_idx_d;
  logic               d_vld_q, d_vld_d;
  logic [IdxW-1:0]    d_idx_q, d_idx_d;
  logic               mag_vld_q, mag_vld_d;
  logic [BoundW-1:0]  best_dist_q, best_dist_d;
  logic [IdxW-1:0]    best_q, best_d;
  logic               exact_q, exact_d;
  logic               done_q, done_d;

  logic               ram_we;
  logic [3*ChanW-1:0] ram_rdata;
  rgb_t               unit_entry;
  logic [DistW-1:0]   unit_dist;
  logic [IdxW-1:0]    last_clamp;
  logic               load_hit;

  // Range clamp and load address check
  assign last_clamp = (range_last_i > IdxW'(LastMax)) ? IdxW'(LastMax) : range_last_i;
  assign load_hit   = 32'(entry_index_i) < 32'(PalEntries);

  // Palette store
  npc_ram #(
    .Width(3 * ChanW),
    .Depth(PalEntries)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(AddrW'(entry_index_i)),
    .wdata_i({red_i, green_i, blue_i}),
    .raddr_i(AddrW'(idx_q)),
    .rdata_o(ram_rdata)
  );

  // Shared distance unit; against black it gives the query magnitude
  assign unit_entry = (state_q == ST_BOUND) ? rgb_t'('0) : rgb_t'(ram_rdata);

  npc_dist u_dist (
    .clk_i    (clk_i),
    .color_a_i(color_q),
    .color_b_i(unit_entry),
    .dist_o   (unit_dist)
  );

  // Sequencer
  always_comb begin
    state_d      = state_q;
    color_d      = color_q;
    idx_d        = idx_q;
    last_d       = last_q;
    issue_done_d = issue_done_q;
    rd_vld_d     = 1'b0;
    rd_idx_d     = rd_idx_q;
    d_vld_d      = rd_vld_q;
    d_idx_d      = rd_idx_q;
    mag_vld_d    = 1'b0;
    best_dist_d  = best_dist_q;
    best_d       = best_q;
    exact_d      = exact_q;
    done_d       = 1'b0;
    ram_we       = 1'b0;

    // read issue, shared by bound and walk states
    if ((state_q != ST_IDLE) && !issue_done_q) begin
      rd_vld_d = 1'b1;
      rd_idx_d = idx_q;
      if (idx_q == last_q) begin
        issue_done_d = 1'b1;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (operation_i == OP_LOAD) begin
            ram_we = load_hit;
          end else begin
            color_d      = '{red: red_i, green: green_i, blue: blue_i};
            idx_d        = range_first_i;
            last_d       = last_clamp;
            issue_done_d = 1'b0;
            best_d       = '0;
            exact_d      = 1'b0;
            if (range_first_i > last_clamp) begin
              done_d = 1'b1;
            end else begin
              state_d = ST_BOUND;
            end
          end
        end
      end
      ST_BOUND: begin
        mag_vld_d = 1'b1;
        state_d   = ST_WALK;
      end
      ST_WALK: begin
        priority if (mag_vld_q) begin
          best_dist_d = {unit_dist, 1'b0};
        end else if (d_vld_q && ({1'b0, unit_dist} < best_dist_q)) begin
          best_dist_d = {1'b0, unit_dist};
          best_d      = d_idx_q;
          if (unit_dist == '0) begin
            // exact hit: flush the pipe and finish
            exact_d  = 1'b1;
            done_d   = 1'b1;
            rd_vld_d = 1'b0;
            d_vld_d  = 1'b0;
            state_d  = ST_IDLE;
          end
        end else begin
          best_dist_d = best_dist_q;
        end
        if (issue_done_q && !rd_vld_q && !done_d) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      issue_done_q <= 1'b1;
      rd_vld_q     <= 1'b0;
      d_vld_q      <= 1'b0;
      mag_vld_q    <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      issue_done_q <= issue_done_d;
      rd_vld_q     <= rd_vld_d;
      d_vld_q      <= d_vld_d;
      mag_vld_q    <= mag_vld_d;
      done_q       <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    color_q     <= color_d;
    idx_q       <= idx_d;
    last_q      <= last_d;
    rd_idx_q    <= rd_idx_d;
    d_idx_q     <= d_idx_d;
    best_dist_q <= best_dist_d;
    best_q      <= best_d;
    exact_q     <= exact_d;
  end

  assign busy          = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign best_index_o  = best_q;
  assign exact_match_o = exact_q;

  // Checks
  `NPC_ASSERT_NOW(a_done_source, done_q,
    $past(state_q == ST_WALK) || $past(start && (state_q == ST_IDLE) && operation_i),
    "result strobe without a query")
  `NPC_ASSERT_NOW(a_read_in_range, rd_vld_q, rd_idx_q <= last_q,
    "palette read beyond range end")
  `NPC_ASSERT_NOW(a_pipe_in_walk, d_vld_q, state_q == ST_WALK,
    "distance word live outside the walk")
  `NPC_ASSERT_NEXT(a_best_shrinks, (state_q == ST_WALK) && !mag_vld_q,
    best_dist_q <= $past(best_dist_q), "best distance grew during walk")

endmodule

`default_nettype wire

// File: verif/nearest_palette_color_checker.sv
// Watches the command and result channels of the nearest palette color block,
// keeps its own palette copy and compares every result word with the answer due.
module nearest_palette_color_checker
  import npc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  logic             operation_i,
  input  logic [IdxW-1:0]  entry_index_i,
  input  logic [ChanW-1:0] red_i,
  input  logic [ChanW-1:0] green_i,
  input  logic [ChanW-1:0] blue_i,
  input  logic [IdxW-1:0]  range_first_i,
  input  logic [IdxW-1:0]  range_last_i,
  input  logic             done_i,
  input  logic [IdxW-1:0]  best_index_i,
  input  logic             exact_match_i,
  output int               fail_count_o,
  output int               answers_due_o
);

  typedef struct packed {
    logic [IdxW-1:0] best_index;
    logic            exact_match;
  } nearest_answer_t;

  rgb_t            palette_copy [PALETTE_ENTRIES];
  nearest_answer_t answers_due [$];
  int              mismatches = 0;
  int              due_count = 0;

  assign fail_count_o  = mismatches;
  assign answers_due_o = due_count;

  initial begin
    foreach (palette_copy[i]) palette_copy[i] = '0;
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH at %0t: %s got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // squared RGB distance between two colors
  function automatic logic [DistW-1:0] color_distance(rgb_t a, rgb_t b);
    logic [ChanW-1:0] dr, dg, db;
    logic [DistW-1:0] sr, sg, sb;
    dr = (a.red >= b.red) ? a.red - b.red : b.red - a.red;
    dg = (a.green >= b.green) ? a.green - b.green : b.green - a.green;
    db = (a.blue >= b.blue) ? a.blue - b.blue : b.blue - a.blue;
    sr = dr * dr;
    sg = dg * dg;
    sb = db * db;
    return sr + sg + sb;
  endfunction

  // walk the inclusive range; bound starts at twice the query magnitude
  function automatic nearest_answer_t nearest_search(rgb_t color, logic [IdxW-1:0] first,
                                                     logic [IdxW-1:0] last);
    logic [DistW-1:0]  mag, entry_dist;
    logic [BoundW-1:0] best_dist;
    nearest_answer_t   ans;
    int                top_idx;
    mag = color.red * color.red + color.green * color.green + color.blue * color.blue;
    best_dist = {mag, 1'b0};
    ans = '0;
    top_idx = (int'(last) > PALETTE_ENTRIES - 1) ? PALETTE_ENTRIES - 1 : int'(last);
    for (int i = int'(first); i <= top_idx; i++) begin
      entry_dist = color_distance(color, palette_copy[i]);
      if (BoundW'(entry_dist) < best_dist) begin
        ans.best_index = IdxW'(i);
        // zero distance stops the walk
        if (entry_dist == '0) begin
          ans.exact_match = 1'b1;
          return ans;
        end
        best_dist = BoundW'(entry_dist);
      end
    end
    return ans;
  endfunction

  // result words are checked before the command accepted at the same edge
  always @(posedge clk_i) begin : watch
    nearest_answer_t want;
    if (rst_ni) begin
      if (done_i) begin
        if (answers_due.size() == 0) begin
          report_mismatch("unexpected result word, best_index", best_index_i, -1);
        end else begin
          want = answers_due.pop_front();
          due_count--;
          if (best_index_i !== want.best_index)
            report_mismatch("best_index", best_index_i, want.best_index);
          if (exact_match_i !== want.exact_match)
            report_mismatch("exact_match", exact_match_i, want.exact_match);
        end
      end
      if (start_i && !busy_i) begin
        if (operation_i == OP_LOAD) begin
          if (int'(entry_index_i) < PALETTE_ENTRIES)
            palette_copy[entry_index_i] = {red_i, green_i, blue_i};
        end else begin
          answers_due.push_back(nearest_search({red_i, green_i, blue_i},
                                               range_first_i, range_last_i));
          due_count++;
        end
      end
    end
  end

endmodule

// File: verif/nearest_palette_color_top_test.sv
// Stimulus and verdict for the nearest palette color block.
module nearest_palette_color_top_test;
  import npc_pkg::*;

  localparam int RandomWords   = 1080;
  localparam int MaxGap        = 40;
  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 10;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic             operation_i;
  logic [IdxW-1:0]  entry_index_i;
  logic [ChanW-1:0] red_i;
  logic [ChanW-1:0] green_i;
  logic [ChanW-1:0] blue_i;
  logic [IdxW-1:0]  range_first_i;
  logic [IdxW-1:0]  range_last_i;
  logic             done_o;
  logic [IdxW-1:0]  best_index_o;
  logic             exact_match_o;

  int fail_count;
  int answers_due;
  int quiet_cycles = 0;
  int idle_pct_plan [3] = '{29, 88, 0};

  // what the stimulus has loaded so far, used to shape queries and loads
  rgb_t shade [PALETTE_ENTRIES];
  bit   loaded [PALETTE_ENTRIES];
  int   loaded_total = 0;

  nearest_palette_color_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .operation_i   (operation_i),
    .entry_index_i (entry_index_i),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .range_first_i (range_first_i),
    .range_last_i  (range_last_i),
    .done_o        (done_o),
    .best_index_o  (best_index_o),
    .exact_match_o (exact_match_o)
  );

  nearest_palette_color_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .operation_i   (operation_i),
    .entry_index_i (entry_index_i),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .range_first_i (range_first_i),
    .range_last_i  (range_last_i),
    .done_i        (done_o),
    .best_index_i  (best_index_o),
    .exact_match_i (exact_match_o),
    .fail_count_o  (fail_count),
    .answers_due_o (answers_due)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // watchdog: cycles with neither a command nor a result word accepted
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit - 1) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // drive one word at a falling edge and hold it until accepted
  task automatic send_word(logic op, logic [IdxW-1:0] idx, rgb_t color,
                           logic [IdxW-1:0] first, logic [IdxW-1:0] last);
    start         <= 1'b1;
    operation_i   <= op;
    entry_index_i <= idx;
    red_i         <= color.red;
    green_i       <= color.green;
    blue_i        <= color.blue;
    range_first_i <= first;
    range_last_i  <= last;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
    if (op == OP_LOAD) begin
      if (!loaded[idx]) loaded_total++;
      loaded[idx] = 1'b1;
      shade[idx]  = color;
    end
  endtask

  task automatic load_entry(logic [IdxW-1:0] idx, rgb_t color);
    send_word(OP_LOAD, idx, color, IdxW'($urandom), IdxW'($urandom));
  endtask

  task automatic query_color(rgb_t color, logic [IdxW-1:0] first, logic [IdxW-1:0] last);
    send_word(OP_QUERY, IdxW'($urandom), color, first, last);
  endtask

  task automatic idle_gap(int pct);
    int n;
    n = 0;
    while (n < MaxGap && $urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      @(negedge clk_i);
      n++;
    end
  endtask

  function automatic logic [ChanW-1:0] rail();
    return $urandom_range(0, 1) ? '1 : '0;
  endfunction

  function automatic logic [ChanW-1:0] nudge(logic [ChanW-1:0] c);
    int v;
    v = int'(c) + $urandom_range(0, 6) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return ChanW'(v);
  endfunction

  // first index from a random start with the wanted load state
  function automatic int scan_entries(bit want_loaded);
    int s, j;
    s = $urandom_range(0, PALETTE_ENTRIES - 1);
    for (int k = 0; k < PALETTE_ENTRIES; k++) begin
      j = (s + k) % PALETTE_ENTRIES;
      if (loaded[j] == want_loaded) return j;
    end
    return -1;
  endfunction

  // one random word: loads, empty ranges and queries over loaded entries only
  task automatic random_word();
    int   pick, idx, lo, hi, first, last, span;
    rgb_t color;
    pick  = $urandom_range(0, 99);
    color = {8'($urandom), 8'($urandom), 8'($urandom)};
    if (pick < 30 || loaded_total == 0) begin
      idx = $urandom_range(0, PALETTE_ENTRIES - 1);
      if (loaded_total < PALETTE_ENTRIES && $urandom_range(0, 1)) idx = scan_entries(1'b0);
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        idx = scan_entries(1'b1) >= 0 ? idx : idx;
        color = shade[scan_entries(1'b1)];
      end else if (pick < 35) begin
        color = {rail(), rail(), rail()};
      end
      load_entry(IdxW'(idx), color);
    end else if (pick < 36) begin
      // inverted range: no entry is read
      first = $urandom_range(1, 255);
      last  = $urandom_range(0, first - 1);
      query_color(color, IdxW'(first), IdxW'(last));
    end else begin
      // range inside one run of loaded entries, mostly narrow
      lo = scan_entries(1'b1);
      hi = lo;
      while (lo > 0 && loaded[lo-1]) lo--;
      while (hi < PALETTE_ENTRIES - 1 && loaded[hi+1]) hi++;
      if ($urandom_range(0, 9) == 0) begin
        first = lo;
        last  = hi;
      end else begin
        span  = $urandom_range(1, 16);
        first = $urandom_range(lo, hi);
        last  = first + $urandom_range(0, (hi - first < span - 1) ? hi - first : span - 1);
      end
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        color = shade[$urandom_range(first, last)];
      end else if (pick < 55) begin
        color = shade[$urandom_range(first, last)];
        color = {nudge(color.red), nudge(color.green), nudge(color.blue)};
      end else if (pick < 60) begin
        color = '0;
      end else if (pick < 65) begin
        color = {rail(), rail(), rail()};
      end
      query_color(color, IdxW'(first), IdxW'(last));
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    start         = 1'b0;
    operation_i   = OP_LOAD;
    entry_index_i = '0;
    red_i         = '0;
    green_i       = '0;
    blue_i        = '0;
    range_first_i = '0;
    range_last_i  = '0;
    foreach (loaded[i]) loaded[i] = 1'b0;
    foreach (shade[i]) shade[i] = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed words
    query_color({8'd9, 8'd9, 8'd9}, 8'd1, 8'd0);        // empty range, nothing loaded yet
    load_entry(8'd0, {8'd0, 8'd0, 8'd0});
    load_entry(8'd1, {8'd255, 8'd255, 8'd255});
    load_entry(8'd2, {8'd10, 8'd20, 8'd30});
    load_entry(8'd3, {8'd10, 8'd20, 8'd30});
    load_entry(8'd4, {8'd12, 8'd20, 8'd30});
    load_entry(8'd255, {8'd255, 8'd0, 8'd255});
    query_color({8'd0, 8'd0, 8'd0}, 8'd0, 8'd4);        // black query, zero bound
    query_color({8'd10, 8'd20, 8'd30}, 8'd1, 8'd4);     // exact hit, earliest duplicate
    query_color({8'd11, 8'd20, 8'd30}, 8'd2, 8'd4);     // three-way tie
    query_color({8'd255, 8'd255, 8'd255}, 8'd0, 8'd1);  // exact on white
    query_color({8'd1, 8'd0, 8'd0}, 8'd1, 8'd1);        // nothing beats the bound
    query_color({8'd255, 8'd0, 8'd255}, 8'd255, 8'd255);
    query_color({8'd0, 8'd255, 8'd0}, 8'd255, 8'd255);  // nothing beats the bound at the top entry
    query_color({8'd254, 8'd254, 8'd254}, 8'd0, 8'd4);
    query_color({8'd50, 8'd50, 8'd50}, 8'd4, 8'd2);     // empty range
    query_color({8'd50, 8'd50, 8'd50}, 8'd255, 8'd0);   // empty range, widest inversion
    load_entry(8'd5, {8'd0, 8'd0, 8'd1});
    query_color({8'd0, 8'd0, 8'd1}, 8'd0, 8'd5);        // near black first, exact later

    // random words in three idling phases
    for (int phase = 0; phase < 3; phase++) begin
      for (int k = 0; k < RandomWords / 3; k++) begin
        idle_gap(idle_pct_plan[phase]);
        random_word();
      end
    end
    start <= 1'b0;

    wait (answers_due == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
